/* rtl/ldl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldl_pkg
// Shared types, constants and the log2 table function for the density unit.
// ----------------------------------------------------------------------------
package ldl_pkg;

  localparam int TBL_FRAC = 24;
  localparam int E_W      = TBL_FRAC + 1;
  localparam int L_W      = 30;
  localparam int MAG_W    = 29;
  localparam int K_W      = 29;

  localparam logic [K_W-1:0] LOG10_2_Q30 = 29'd323228497;

  typedef struct packed {
    logic valid;
    logic final_flag;
  } ldl_ctrl_t;

  // log2(1 + i/2^tbits) in Q1.24, bit by bit through repeated squaring
  function automatic logic [E_W-1:0] log2_rom_entry(input int unsigned i,
                                                    input int unsigned tbits);
    logic [63:0]     y;
    logic [E_W-1:0]  r;
    int              k;
    r = '0;
    if (i >= (32'd1 << tbits)) begin
      r = E_W'(1) << TBL_FRAC;
    end else begin
      y = (64'd1 << 30) + (64'(i) << (30 - tbits));
      for (k = TBL_FRAC - 1; k >= 0; k--) begin
        y = (y * y) >> 30;
        if (y >= (64'd1 << 31)) begin
          y    = y >> 1;
          r[k] = 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage

/* rtl/ldl_log2.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldl_log2
// Four-stage log2 pipeline: leading one and normalize, table read,
// interpolation multiply, exponent merge with magnitude and sign.
// ----------------------------------------------------------------------------
module ldl_log2 import ldl_pkg::*; #(
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  ldl_ctrl_t        ctrl_i,
  input  logic [31:0]      level_i,
  output ldl_ctrl_t        ctrl_o,
  output logic             neg_o,
  output logic [MAG_W-1:0] mag_o
);

  localparam int REM    = 31 - LOG_TABLE_BITS;
  localparam int ROM_N  = (1 << LOG_TABLE_BITS) + 1;
  localparam int PROD_W = E_W + REM;

  logic [E_W-1:0] rom [ROM_N];

  for (genvar g = 0; g < ROM_N; g++) begin : g_rom
    assign rom[g] = log2_rom_entry(g, LOG_TABLE_BITS);
  end

  // stage 2: leading one, normalize
  logic [4:0]  msb;
  logic [31:0] norm;
  ldl_ctrl_t   ctrl2_q;
  logic [4:0]  msb2_q;
  logic [30:0] frac2_q;

  always_comb begin
    msb = '0;
    for (int b = 0; b < 32; b++) begin
      if (level_i[b]) begin
        msb = 5'(b);
      end
    end
    norm = level_i << (5'd31 - msb);
  end

  // stage 3: table read
  logic [LOG_TABLE_BITS:0] idx0;
  logic [LOG_TABLE_BITS:0] idx1;
  ldl_ctrl_t               ctrl3_q;
  logic [4:0]              msb3_q;
  logic [E_W-1:0]          e0_3_q;
  logic [E_W-1:0]          e1_3_q;
  logic [REM-1:0]          w3_q;

  assign idx0 = {1'b0, frac2_q[30:REM]};
  assign idx1 = idx0 + (LOG_TABLE_BITS+1)'(1);

  // stage 4: slope times remainder
  logic [E_W-1:0]    diff;
  ldl_ctrl_t         ctrl4_q;
  logic [4:0]        msb4_q;
  logic [E_W-1:0]    e0_4_q;
  logic [PROD_W-1:0] prod4_q;

  assign diff = e1_3_q - e0_3_q;

  // stage 5: log2 in Q.24, magnitude and sign
  logic [E_W-1:0]       l2;
  logic signed [5:0]    expo;
  logic signed [L_W-1:0] l_val;
  logic [L_W-1:0]       l_abs;
  ldl_ctrl_t            ctrl5_q;
  logic                 neg5_q;
  logic [MAG_W-1:0]     mag5_q;

  always_comb begin
    l2    = e0_4_q + prod4_q[REM +: E_W];
    expo  = $signed({1'b0, msb4_q}) - 6'sd16;
    l_val = $signed({expo, {TBL_FRAC{1'b0}}}) + $signed(L_W'(l2));
    l_abs = l_val[L_W-1] ? L_W'(-l_val) : L_W'(l_val);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl2_q <= '0;
      ctrl3_q <= '0;
      ctrl4_q <= '0;
      ctrl5_q <= '0;
    end else if (en_i) begin
      ctrl2_q <= ctrl_i;
      ctrl3_q <= ctrl2_q;
      ctrl4_q <= ctrl3_q;
      ctrl5_q <= ctrl4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      msb2_q  <= msb;
      frac2_q <= norm[30:0];
      msb3_q  <= msb2_q;
      e0_3_q  <= rom[idx0];
      e1_3_q  <= rom[idx1];
      w3_q    <= frac2_q[REM-1:0];
      msb4_q  <= msb3_q;
      e0_4_q  <= e0_3_q;
      prod4_q <= PROD_W'(diff) * PROD_W'(w3_q);
      neg5_q  <= l_val[L_W-1];
      mag5_q  <= l_abs[MAG_W-1:0];
    end
  end

  assign ctrl_o = ctrl5_q;
  assign neg_o  = neg5_q;
  assign mag_o  = mag5_q;

endmodule

/* rtl/light_to_density_log_converter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_to_density_log_converter_unit
// Optical density -log10(level) of a floor-clamped Q16.16 light level,
// signed result with FRACTION_BITS fraction bits.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------
//  in       | in_valid_i / in_stall_o  | light_level_i, final_item_i
//  out      | out_valid_o / out_stall_i| density_value_o, final_out_o
//  cfg      | cfg_we_i                 | cfg_wdata_i (floor level)
//
//  Seven register stages, the last one driving the outputs. The single
//  shared stage enable lets a new item enter every cycle while the
//  result is not stalled. A stalled result freezes every stage;
//  nothing moves until it is taken. Reset clears all stage valid bits
//  and sets the floor to one LSB.
// ----------------------------------------------------------------------------
module light_to_density_log_converter_unit import ldl_pkg::*; #(
  parameter int LOG_TABLE_BITS = 8,
  parameter int FRACTION_BITS  = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] light_level_i,
  input  logic        final_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] density_value_o,
  output logic        final_out_o
);

  localparam int P_W = MAG_W + K_W;
  localparam int S   = TBL_FRAC + 30 - FRACTION_BITS;

  localparam logic [15:0] SAT_POS = 16'h7FFF;
  localparam logic [15:0] SAT_NEG = 16'h8000;

  logic en;

  // floor register
  logic [31:0] floor_level_q;
  logic [31:0] floor_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_level_q <= 32'd1;
    end else if (cfg_we_i) begin
      floor_level_q <= cfg_wdata_i;
    end
  end

  assign floor_eff = (floor_level_q == '0) ? 32'd1 : floor_level_q;

  // stage 1: clamp
  ldl_ctrl_t   ctrl1_q;
  logic [31:0] x1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
    end else if (en) begin
      ctrl1_q <= '{valid: in_valid_i, final_flag: final_item_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q <= (light_level_i > floor_eff) ? light_level_i : floor_eff;
    end
  end

  // stages 2..5
  ldl_ctrl_t        ctrl5;
  logic             neg5;
  logic [MAG_W-1:0] mag5;

  ldl_log2 #(
    .LOG_TABLE_BITS(LOG_TABLE_BITS)
  ) u_log2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctrl_i (ctrl1_q),
    .level_i(x1_q),
    .ctrl_o (ctrl5),
    .neg_o  (neg5),
    .mag_o  (mag5)
  );

  // stage 6: scale by log10(2)
  ldl_ctrl_t      ctrl6_q;
  logic           neg6_q;
  logic [P_W-1:0] p6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl6_q <= '0;
    end else if (en) begin
      ctrl6_q <= ctrl5;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg6_q <= neg5;
      p6_q   <= P_W'(mag5) * P_W'(LOG10_2_Q30);
    end
  end

  // stage 7: round half up on magnitude, sign, saturate
  logic [P_W:0]  rsum;
  logic [P_W:0]  rshift;
  logic [63:0]   r64;
  logic [15:0]   density_d;
  logic [15:0]   density_q;
  logic          final_q;
  logic          out_valid_q;

  always_comb begin
    rsum   = {1'b0, p6_q} + ((P_W+1)'(1) << (S - 1));
    rshift = rsum >> S;
    r64    = 64'(rshift);
    if (neg6_q) begin
      density_d = (r64 > 64'd32767) ? SAT_POS : r64[15:0];
    end else begin
      density_d = (r64 > 64'd32768) ? SAT_NEG : 16'(~r64[15:0] + 16'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctrl6_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      density_q <= density_d;
      final_q   <= ctrl6_q.final_flag;
    end
  end

  assign en              = !(out_valid_q && out_stall_i);
  assign in_stall_o      = !en;
  assign out_valid_o     = out_valid_q;
  assign density_value_o = density_q;
  assign final_out_o     = final_q;

  a_floor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    floor_eff != '0)
    else $error("effective floor is zero");

  a_mag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl5.valid |-> mag5 <= (MAG_W'(1) << (MAG_W - 1)))
    else $error("log2 magnitude out of range");

  a_sign_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && ctrl6_q.valid && !neg6_q) |=> $signed(density_value_o) <= 16'sd0)
    else $error("density sign wrong for level at or above one");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(p6_q) && $stable(ctrl6_q))
    else $error("stage 6 moved during stall");

endmodule

/* test/tb_light_to_density_log_converter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_light_to_density_log_converter_unit
// Drives Q16.16 light levels through the density unit under random input
// gaps and output stalls, and checks every result against an in-bench
// predictor of the floor clamp, table log2 and log10 scaling.
// ----------------------------------------------------------------------------
module tb_light_to_density_log_converter_unit;

  localparam int TBITS       = 8;
  localparam int FBITS       = 12;
  localparam int REM_BITS    = 31 - TBITS;
  localparam int PT_FRAC     = 24;
  localparam int RND_SHIFT   = PT_FRAC + 30 - FBITS;
  localparam longint unsigned LOG10_2 = 64'd323228497;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 12;

  typedef struct packed {
    logic [15:0] density;
    logic        fin;
  } density_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] light_level = '0;
  logic        final_item = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] density_value;
  logic        final_out;

  logic [PT_FRAC:0] log2_points [0:(1 << TBITS)];
  density_result_t  density_q [$];
  logic [31:0]      floor_model = 32'd1;

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned floors_used = 1;
  bit          idle_on = 1'b0;
  int unsigned hold_req = 0;
  int unsigned hold_count = 0;
  int unsigned burst_left = 0;

  light_to_density_log_converter_unit DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .light_level_i  (light_level),
    .final_item_i   (final_item),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .density_value_o(density_value),
    .final_out_o    (final_out)
  );

  always #10 clk = ~clk;

  // log2(1 + i/2^TBITS) in Q1.24 by repeated squaring
  function automatic logic [PT_FRAC:0] log2_point(int unsigned i);
    longint unsigned y;
    logic [PT_FRAC:0] r;
    r = '0;
    if (i >= (1 << TBITS)) begin
      r = (PT_FRAC+1)'(1) << PT_FRAC;
    end else begin
      y = (64'd1 << 30) + (longint'(i) << (30 - TBITS));
      for (int k = PT_FRAC - 1; k >= 0; k--) begin
        y = (y * y) >> 30;
        if (y >= (64'd1 << 31)) begin
          y    = y >> 1;
          r[k] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  initial begin
    for (int i = 0; i <= (1 << TBITS); i++) log2_points[i] = log2_point(i);
  end

  function automatic logic [15:0] predict_density(logic [31:0] level, logic [31:0] flr);
    logic [31:0]     fl;
    logic [31:0]     x;
    int              msb;
    longint unsigned frac, w, idx, e0, e1, l2, mag, p, r;
    longint          lg, d;
    fl  = (flr == 0) ? 32'd1 : flr;
    x   = (level > fl) ? level : fl;
    msb = 31;
    while (msb > 0 && x[msb] == 1'b0) msb--;
    frac = ((longint'(x) << (31 - msb)) & 64'hFFFF_FFFF) & 64'h7FFF_FFFF;
    idx  = frac >> REM_BITS;
    w    = frac & ((64'd1 << REM_BITS) - 1);
    e0   = 64'(log2_points[idx]);
    e1   = 64'(log2_points[idx + 1]);
    l2   = e0 + (((e1 - e0) * w) >> REM_BITS);
    lg   = longint'(msb - 16) * (64'sd1 << PT_FRAC) + longint'(l2);
    mag  = (lg < 0) ? longint'(-lg) : longint'(lg);
    p    = mag * LOG10_2;
    r    = (p + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
    d    = (lg < 0) ? longint'(r) : -longint'(r);
    if (d > 32767) d = 32767;
    if (d < -32768) d = -32768;
    return d[15:0];
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
  endtask

  // caller is at a rising edge; leaves valid high at the accepting edge
  task automatic send_item(logic [31:0] lvl, logic fin);
    density_result_t res;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    light_level <= lvl;
    final_item  <= fin;
    do @(posedge clk); while (in_stall);
    res.density = predict_density(lvl, floor_model);
    res.fin     = fin;
    density_q.push_back(res);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (density_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_floor(logic [31:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we      <= 1'b0;
    floor_model = val;
    floors_used++;
  endtask

  function automatic logic [31:0] pick_level();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0:       v = $urandom_range(0, 32'hFFFF);
      1:       v = 32'd1 << $urandom_range(0, 31);
      2:       v = (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 4) - 2;
      3:       v = floor_model + $urandom_range(0, 4) - 2;
      4:       v = $urandom >> $urandom_range(0, 31);
      5:       v = 32'h0001_0000 + $urandom_range(0, 64) - 32;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_floor();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = 32'd0;
      1:       v = 32'd1;
      2:       v = 32'hFFFF_FFFF;
      3:       v = $urandom_range(1, 32'hFFFF);
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  // output stall: long holds on request, otherwise random bursts
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_count = hold_req;
      hold_req   = 0;
    end
    if (hold_count != 0) begin
      hold_count--;
      out_stall <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(1, 13) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    density_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (density_q.size() == 0) begin
        report_mismatch("unexpected item", {16'd0, density_value}, 32'd0);
      end else begin
        want = density_q.pop_front();
        results_checked++;
        if (density_value !== want.density)
          report_mismatch("density_value", {16'd0, density_value}, {16'd0, want.density});
        if (final_out !== want.fin)
          report_mismatch("final_out", {31'd0, final_out}, {31'd0, want.fin});
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               density_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_reset_floor_extremes();
    logic [31:0] lv [] = '{32'h0, 32'h1, 32'h2, 32'hFFFF_FFFF, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_FFFF, 32'h0001_0001,
                           32'h0000_8000, 32'h0002_0000, 32'h000A_0000, 32'h0064_0000,
                           32'h0000_199A, 32'h0000_0666, 32'h5555_5555, 32'hAAAA_AAAA,
                           32'h0001_8000};
    idle_on = 1'b1;
    foreach (lv[i]) send_item(lv[i], i[0]);
    drain();
  endtask

  task automatic test_floor_settings();
    logic [31:0] fl [] = '{32'd0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0100};
    foreach (fl[i]) begin
      write_floor(fl[i]);
      send_item(32'h0, 1'b0);
      send_item(fl[i] - 1, 1'b0);
      send_item(fl[i], 1'b1);
      send_item(fl[i] + 1, 1'b0);
      send_item(32'hFFFF_FFFF, 1'b1);
      repeat (10) send_item(pick_level(), 1'($urandom_range(0, 1)));
    end
    drain();
  endtask

  task automatic test_random_levels();
    for (int ph = 0; ph < 30; ph++) begin
      write_floor(pick_floor());
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (55) send_item(pick_level(), $urandom_range(0, 7) == 0);
    end
    drain();
  endtask

  task automatic test_output_backpressure();
    write_floor(32'd1);
    idle_on  = 1'b0;
    hold_req = 200;
    repeat (40) send_item(pick_level(), 1'($urandom_range(0, 1)));
    drain();
  endtask

  task automatic test_streaming();
    write_floor(pick_floor());
    idle_on = 1'b0;
    repeat (200) send_item(pick_level(), $urandom_range(0, 7) == 0);
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_floor_extremes();
    test_floor_settings();
    test_random_levels();
    test_output_backpressure();
    test_streaming();
    $display("Sent %0d light levels under %0d floor settings, %0d densities checked",
             items_sent, floors_used, results_checked);
    $display("Covered range extremes, zero and saturated floors, long output holds");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
